// ----- rtl/itra_pkg.sv -----
package itra_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned DIGIT_DEPTH = 64;
  localparam int unsigned DIGIT_IDX_W = 6;
  localparam int unsigned BIT_IDX_W   = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 7'd32;

  // One classified number waiting for conversion.
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               negative;
    logic [RADIX_W-1:0] radix;
    logic               upper;
  } job_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                    input logic upper);
    logic [RADIX_W-1:0] off;
    off = d - DIGIT_TEN;
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + {1'b0, d};
    end
    return CHAR_LOWER_A - (upper ? CASE_OFFSET : 7'd0) + {1'b0, off};
  endfunction

endpackage

// ----- rtl/itra_if.sv -----
interface itra_in_if import itra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               is_signed;
  logic [RADIX_W-1:0] radix;
  logic               upper_case;

  modport source (output valid, value, is_signed, radix, upper_case, input ready);
  modport sink   (input valid, value, is_signed, radix, upper_case, output ready);
endinterface

interface itra_out_if import itra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  character;
  logic               last;
  logic [COUNT_W-1:0] char_count;

  modport source (output valid, character, last, char_count, input ready);
  modport sink   (input valid, character, last, char_count, output ready);
endinterface

// ----- rtl/itra_front.sv -----
module itra_front import itra_pkg::*; (
  itra_in_if.sink in_i,
  output logic    push_valid_o,
  output job_t    push_job_o,
  input  logic    push_ready_i
);

  logic [31:0] low;

  assign low          = in_i.value[31:0];
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    push_job_o = '0;
    if (in_i.radix < RADIX_MIN) begin
      push_job_o.radix = RADIX_MIN;
    end else if (in_i.radix > RADIX_MAX) begin
      push_job_o.radix = RADIX_MAX;
    end else begin
      push_job_o.radix = in_i.radix;
    end
    push_job_o.upper = in_i.upper_case;
    if (in_i.is_signed) begin
      // The negation of the most negative word is that word again, which is
      // exactly the magnitude wanted when read as unsigned.
      push_job_o.negative = low[31];
      push_job_o.mag      = low[31] ? {32'd0, ~low + 32'd1} : {32'd0, low};
    end else begin
      push_job_o.negative = 1'b0;
      push_job_o.mag      = in_i.value;
    end
  end

endmodule

// ----- rtl/itra_queue.sv -----
module itra_queue import itra_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  job_t push_job_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output job_t pop_job_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- rtl/itra_back.sv -----
module itra_back import itra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pop_valid_i,
  input  job_t pop_job_i,
  output logic pop_ready_o,
  itra_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_RD,
    S_LOAD
  } state_e;

  localparam logic [BIT_IDX_W-1:0] BitLast   = BIT_IDX_W'(VALUE_W - 1);
  localparam logic [COUNT_W-1:0]   DigitLast = COUNT_W'(DIGIT_DEPTH - 1);

  state_e               state_q;
  logic [VALUE_W-1:0]   quo_q;
  logic [RADIX_W-1:0]   rem_q;
  logic [RADIX_W-1:0]   radix_q;
  logic                 upper_q;
  logic                 neg_q;
  logic [BIT_IDX_W-1:0] bit_q;
  logic [COUNT_W-1:0]   nd_q;
  logic [DIGIT_IDX_W-1:0] ridx_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic                 ov_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;
  logic [COUNT_W-1:0]   count_q;

  logic [RADIX_W-1:0]   digit_mem [DIGIT_DEPTH];
  logic [RADIX_W-1:0]   rd_data_q;

  logic [RADIX_W:0]     trial;
  logic                 ge;
  logic [RADIX_W-1:0]   rem_next;
  logic [VALUE_W-1:0]   quo_next;
  logic                 slot_free;
  logic                 char_emit;
  logic                 mem_we;

  assign out_o.valid      = ov_q;
  assign out_o.character  = char_q;
  assign out_o.last       = last_q;
  assign out_o.char_count = count_q;
  assign pop_ready_o      = (state_q == S_IDLE);
  assign slot_free        = !ov_q || out_o.ready;
  assign char_emit        = slot_free && ((state_q == S_SIGN) || (state_q == S_LOAD));

  // One restoring step: bring down the next dividend bit and try the radix.
  assign trial    = {rem_q, quo_q[VALUE_W-1]};
  assign ge       = (trial >= {1'b0, radix_q});
  assign rem_next = ge ? RADIX_W'(trial - {1'b0, radix_q}) : RADIX_W'(trial);
  assign quo_next = {quo_q[VALUE_W-2:0], ge};
  assign mem_we   = (state_q == S_DIV) && (bit_q == BitLast);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[nd_q[DIGIT_IDX_W-1:0]] <= rem_next;
    end
    rd_data_q <= digit_mem[ridx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      quo_q   <= '0;
      rem_q   <= '0;
      radix_q <= RADIX_MIN;
      upper_q <= 1'b0;
      neg_q   <= 1'b0;
      bit_q   <= '0;
      nd_q    <= '0;
      ridx_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      char_q  <= '0;
      last_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (out_o.ready && !char_emit) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            quo_q   <= pop_job_i.mag;
            rem_q   <= '0;
            radix_q <= pop_job_i.radix;
            upper_q <= pop_job_i.upper;
            neg_q   <= pop_job_i.negative;
            bit_q   <= '0;
            nd_q    <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_q == BitLast) begin
            // A digit is complete; the quotient becomes the next dividend.
            nd_q  <= nd_q + COUNT_W'(1);
            quo_q <= quo_next;
            rem_q <= '0;
            bit_q <= '0;
            if (quo_next == '0 || nd_q == DigitLast) begin
              ridx_q  <= nd_q[DIGIT_IDX_W-1:0];
              state_q <= neg_q ? S_SIGN : S_RD;
            end
          end else begin
            quo_q <= quo_next;
            rem_q <= rem_next;
            bit_q <= bit_q + BIT_IDX_W'(1);
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            ov_q    <= 1'b1;
            char_q  <= CHAR_MINUS;
            last_q  <= 1'b0;
            count_q <= cnt_q + COUNT_W'(1);
            cnt_q   <= cnt_q + COUNT_W'(1);
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) begin
            ov_q    <= 1'b1;
            char_q  <= digit_char(rd_data_q, upper_q);
            last_q  <= (ridx_q == '0);
            count_q <= cnt_q + COUNT_W'(1);
            cnt_q   <= cnt_q + COUNT_W'(1);
            if (ridx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              ridx_q  <= ridx_q - DIGIT_IDX_W'(1);
              state_q <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/integer_to_radix_ascii.sv -----
// Prints one number per input word as ASCII characters, one output word per
// character, most significant digit first, with a leading minus sign for a
// negative signed value. The front end classifies each word at once and
// parks it in a small queue, so a new number is taken while the previous one
// is still being converted. Conversion uses a bit-serial restoring divider
// that produces the digits least significant first, then reads them back
// from a 64-entry store, most significant first, one character at a time.
module integer_to_radix_ascii import itra_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itra_in_if.sink     in_i,
  itra_out_if.source  out_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  itra_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  itra_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_ready_i  (pop_ready)
  );

  itra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_job_i   (pop_job),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

// ----- tb/integer_to_radix_ascii_test.sv -----
module integer_to_radix_ascii_test;
  import itra_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS = 120;

  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] char_count;
  } text_char_t;

  class radix_text_scoreboard;
    text_char_t  pending_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Works out the characters one accepted number must produce.
    function void note_number(logic [VALUE_W-1:0] value, logic is_signed,
                              logic [RADIX_W-1:0] radix, logic upper);
      logic [VALUE_W-1:0] mag;
      logic [31:0]        low;
      logic               negative;
      int unsigned        base;
      logic [RADIX_W-1:0] digits[DIGIT_DEPTH];
      int                 nd;
      int                 k;
      int                 i;
      text_char_t         c;
      base = radix;
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > RADIX_MAX) base = RADIX_MAX;
      negative = 1'b0;
      if (is_signed) begin
        low = value[31:0];
        negative = low[31];
        // The 32-bit negation of the most negative value is its own magnitude.
        if (negative) low = ~low + 32'd1;
        mag = {32'd0, low};
      end else begin
        mag = value;
      end
      nd = 0;
      do begin
        digits[nd] = RADIX_W'(mag % base);
        mag = mag / base;
        nd++;
      end while (mag != 0 && nd < DIGIT_DEPTH);
      k = 0;
      if (negative) begin
        k++;
        c.character = CHAR_MINUS;
        c.last = 1'b0;
        c.char_count = COUNT_W'(k);
        pending_chars.push_back(c);
      end
      for (i = nd - 1; i >= 0; i--) begin
        k++;
        if (digits[i] < DIGIT_TEN) begin
          c.character = CHAR_ZERO + CHAR_W'(digits[i]);
        end else begin
          c.character = (upper ? CHAR_LOWER_A - CASE_OFFSET : CHAR_LOWER_A) +
                        CHAR_W'(digits[i] - DIGIT_TEN);
        end
        c.last = (i == 0);
        c.char_count = COUNT_W'(k);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] character, logic last,
                             logic [COUNT_W-1:0] char_count);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character word: character %0h, last %0d, char_count %0d",
               character, last, char_count);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (character !== want.character) begin
        $error("character mismatch: expected %0h, actual %0h", want.character, character);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, last);
        mismatches++;
      end
      if (char_count !== want.char_count) begin
        $error("char_count mismatch: expected %0d, actual %0d", want.char_count, char_count);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        char_ready = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned char_stall_pct = 0;
  int unsigned cycle_count = 0;

  radix_text_scoreboard board = new();

  itra_in_if  in_if();
  itra_out_if out_if();

  assign out_if.ready = char_ready;

  integer_to_radix_ascii uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Character sink: checks each accepted word and draws a new stall decision.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && char_ready) begin
        board.check_char(out_if.character, out_if.last, out_if.char_count);
      end
      char_ready <= ($urandom_range(0, 99) >= char_stall_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_number(input logic [VALUE_W-1:0] value, input logic is_signed,
                             input logic [RADIX_W-1:0] radix, input logic upper);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.value      <= value;
    in_if.is_signed  <= is_signed;
    in_if.radix      <= radix;
    in_if.upper_case <= upper;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_number(value, is_signed, radix, upper);
  endtask

  // Mostly short magnitudes keep the run fast; a few reach the full width.
  task automatic send_random_number();
    logic [VALUE_W-1:0] value;
    logic [31:0]        low;
    logic               is_signed;
    logic [RADIX_W-1:0] radix;
    int unsigned        width;
    is_signed = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 15))
      0: radix = RADIX_W'($urandom_range(0, 63));
      1: radix = 6'd2;
      default: radix = RADIX_W'($urandom_range(2, 36));
    endcase
    if ($urandom_range(0, 7) == 0) width = $urandom_range(0, 64);
    else width = $urandom_range(0, 20);
    value = {$urandom, $urandom};
    if (width < 64) value = value & ((64'd1 << width) - 64'd1);
    if (is_signed) begin
      low = value[31:0];
      if ($urandom_range(0, 1)) low = -low;
      value = {$urandom, low};
    end
    send_number(value, is_signed, radix, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    char_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_random_number();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.value      <= '0;
    in_if.is_signed  <= 1'b0;
    in_if.radix      <= RADIX_MIN;
    in_if.upper_case <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_number(64'd0, 1'b0, 6'd10, 1'b0);
    send_number(64'd0, 1'b1, 6'd2, 1'b1);
    send_number('1, 1'b0, 6'd2, 1'b0);
    send_number('1, 1'b0, 6'd36, 1'b0);
    send_number('1, 1'b0, 6'd16, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b0, 6'd10, 1'b0);
    send_number(64'h0000_0000_8000_0000, 1'b1, 6'd10, 1'b0);
    send_number(64'h0000_0000_8000_0000, 1'b1, 6'd2, 1'b0);
    send_number(64'h0000_0000_7fff_ffff, 1'b1, 6'd2, 1'b0);
    // Upper bits set in signed mode must not affect the digits.
    send_number(64'hffff_ffff_ffff_ffff, 1'b1, 6'd10, 1'b0);
    send_number(64'ha5a5_5a5a_0000_007b, 1'b1, 6'd16, 1'b1);
    send_number(64'd35, 1'b0, 6'd36, 1'b0);
    send_number(64'd35, 1'b0, 6'd36, 1'b1);
    send_number(64'd10, 1'b0, 6'd11, 1'b0);
    send_number(64'd9, 1'b0, 6'd10, 1'b0);
    send_number(64'd255, 1'b0, 6'd0, 1'b0);
    send_number(64'd255, 1'b0, 6'd1, 1'b0);
    send_number(64'd1295, 1'b0, 6'd37, 1'b1);
    send_number(64'd1295, 1'b0, 6'd63, 1'b0);
    send_number(64'h0000_0000_ffff_ff85, 1'b1, 6'd36, 1'b1);

    run_phase(0, 0);
    run_phase(76, 0);
    run_phase(0, 76);
    run_phase(38, 38);
    in_if.valid <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
